// File: rtl/core/sbx_pkg.sv
// Shared types, constants and substitution tables for the S-box ARX keystream cipher.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package sbx_pkg;

  localparam int NumWords = 12;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int CfgIdxW  = 3;

  // Start constants, each XORed with its nonce half
  localparam logic [31:0] InitW8  = 32'ha9856d6b;
  localparam logic [31:0] InitW9  = 32'hf906a604;
  localparam logic [31:0] InitW10 = 32'he12dc19c;
  localparam logic [31:0] InitW11 = 32'hb66329a0;

  // Warm-up updates run after a start
  localparam logic [1:0] WarmUpdates = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_A   = 3'd0,
    REG_KEY_B   = 3'd1,
    REG_KEY_C   = 3'd2,
    REG_KEY_D   = 3'd3,
    REG_NONCE_A = 3'd4,
    REG_NONCE_B = 3'd5
  } sbx_reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRE  = 2'd1,
    PH_SUB  = 2'd2,
    PH_POST = 2'd3
  } sbx_phase_t;

  typedef struct packed {
    logic        is_start;
    logic [1:0]  pos;
    logic [7:0]  data;
  } sbx_op_t;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [63:0] nonce_a;
    logic [63:0] nonce_b;
  } sbx_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sbx_qstat_t;

  localparam logic [7:0] SboxA [0:255] = '{
    8'd93,8'd189,8'd55,8'd134,8'd51,8'd103,8'd232,8'd238,
    8'd137,8'd32,8'd124,8'd81,8'd108,8'd175,8'd161,8'd225,
    8'd40,8'd250,8'd222,8'd122,8'd234,8'd27,8'd193,8'd10,
    8'd14,8'd216,8'd82,8'd167,8'd180,8'd74,8'd212,8'd252,
    8'd142,8'd200,8'd136,8'd150,8'd66,8'd131,8'd190,8'd143,
    8'd43,8'd160,8'd227,8'd37,8'd224,8'd113,8'd72,8'd9,
    8'd242,8'd110,8'd153,8'd92,8'd17,8'd73,8'd31,8'd54,
    8'd50,8'd223,8'd253,8'd231,8'd239,8'd158,8'd139,8'd233,
    8'd80,8'd75,8'd144,8'd237,8'd126,8'd34,8'd22,8'd35,
    8'd248,8'd195,8'd154,8'd166,8'd67,8'd28,8'd99,8'd11,
    8'd100,8'd163,8'd63,8'd249,8'd155,8'd203,8'd97,8'd141,
    8'd128,8'd52,8'd87,8'd38,8'd88,8'd47,8'd228,8'd104,
    8'd68,8'd33,8'd5,8'd178,8'd12,8'd132,8'd86,8'd205,
    8'd147,8'd129,8'd42,8'd179,8'd102,8'd156,8'd217,8'd16,
    8'd171,8'd168,8'd3,8'd6,8'd240,8'd244,8'd71,8'd219,
    8'd94,8'd19,8'd48,8'd157,8'd77,8'd151,8'd170,8'd194,
    8'd148,8'd91,8'd0,8'd226,8'd114,8'd187,8'd41,8'd101,
    8'd218,8'd246,8'd76,8'd56,8'd236,8'd116,8'd29,8'd106,
    8'd198,8'd119,8'd201,8'd89,8'd120,8'd2,8'd115,8'd221,
    8'd112,8'd1,8'd30,8'd18,8'd243,8'd152,8'd123,8'd196,
    8'd235,8'd13,8'd78,8'd209,8'd145,8'd84,8'd125,8'd202,
    8'd70,8'd49,8'd206,8'd53,8'd176,8'd183,8'd251,8'd159,
    8'd182,8'd210,8'd169,8'd181,8'd186,8'd7,8'd8,8'd65,
    8'd36,8'd127,8'd185,8'd61,8'd95,8'd245,8'd111,8'd214,
    8'd162,8'd39,8'd138,8'd184,8'd26,8'd191,8'd213,8'd230,
    8'd173,8'd44,8'd146,8'd192,8'd79,8'd241,8'd107,8'd172,
    8'd140,8'd98,8'd135,8'd105,8'd207,8'd96,8'd24,8'd177,
    8'd121,8'd45,8'd25,8'd229,8'd208,8'd21,8'd83,8'd220,
    8'd165,8'd46,8'd57,8'd62,8'd204,8'd58,8'd85,8'd23,
    8'd90,8'd255,8'd64,8'd133,8'd164,8'd215,8'd59,8'd149,
    8'd197,8'd199,8'd118,8'd20,8'd15,8'd117,8'd174,8'd211,
    8'd247,8'd69,8'd254,8'd109,8'd60,8'd188,8'd130,8'd4
  };

  localparam logic [7:0] SboxB [0:255] = '{
    8'd153,8'd79,8'd48,8'd69,8'd228,8'd117,8'd106,8'd251,
    8'd205,8'd220,8'd105,8'd57,8'd46,8'd3,8'd37,8'd217,
    8'd158,8'd233,8'd62,8'd213,8'd89,8'd119,8'd229,8'd144,
    8'd218,8'd27,8'd75,8'd192,8'd127,8'd231,8'd178,8'd80,
    8'd42,8'd24,8'd53,8'd134,8'd133,8'd250,8'd189,8'd160,
    8'd175,8'd43,8'd103,8'd124,8'd247,8'd237,8'd100,8'd68,
    8'd244,8'd31,8'd34,8'd70,8'd163,8'd121,8'd215,8'd108,
    8'd238,8'd180,8'd162,8'd5,8'd4,8'd239,8'd226,8'd17,
    8'd181,8'd199,8'd198,8'd172,8'd236,8'd171,8'd116,8'd51,
    8'd90,8'd173,8'd19,8'd148,8'd165,8'd63,8'd115,8'd76,
    8'd182,8'd161,8'd129,8'd10,8'd234,8'd56,8'd211,8'd50,
    8'd126,8'd131,8'd83,8'd174,8'd146,8'd13,8'd95,8'd157,
    8'd186,8'd67,8'd253,8'd176,8'd188,8'd212,8'd21,8'd248,
    8'd159,8'd91,8'd193,8'd2,8'd40,8'd169,8'd29,8'd101,
    8'd98,8'd155,8'd168,8'd135,8'd136,8'd15,8'd120,8'd203,
    8'd113,8'd225,8'd52,8'd71,8'd33,8'd49,8'd1,8'd130,
    8'd104,8'd85,8'd170,8'd99,8'd202,8'd38,8'd156,8'd73,
    8'd210,8'd25,8'd28,8'd14,8'd84,8'd6,8'd243,8'd222,
    8'd147,8'd246,8'd11,8'd184,8'd122,8'd223,8'd197,8'd245,
    8'd20,8'd58,8'd195,8'd114,8'd26,8'd77,8'd65,8'd109,
    8'd230,8'd227,8'd41,8'd208,8'd123,8'd32,8'd44,8'd36,
    8'd235,8'd23,8'd221,8'd145,8'd64,8'd141,8'd167,8'd138,
    8'd102,8'd191,8'd209,8'd214,8'd241,8'd137,8'd128,8'd18,
    8'd194,8'd206,8'd151,8'd110,8'd204,8'd164,8'd224,8'd249,
    8'd166,8'd30,8'd242,8'd254,8'd107,8'd94,8'd183,8'd61,
    8'd86,8'd93,8'd7,8'd54,8'd252,8'd47,8'd8,8'd125,
    8'd82,8'd74,8'd35,8'd92,8'd201,8'd16,8'd190,8'd154,
    8'd207,8'd112,8'd140,8'd149,8'd179,8'd87,8'd55,8'd142,
    8'd60,8'd139,8'd12,8'd111,8'd59,8'd97,8'd177,8'd118,
    8'd66,8'd22,8'd45,8'd240,8'd187,8'd152,8'd132,8'd78,
    8'd219,8'd72,8'd185,8'd0,8'd96,8'd39,8'd81,8'd200,
    8'd255,8'd150,8'd196,8'd143,8'd88,8'd216,8'd9,8'd232
  };

  // Byte-wise substitution: byte k of a XOR table[byte k of b]; sel bit k picks table B
  function automatic logic [31:0] subst(input logic [31:0] a, input logic [31:0] b,
                                        input logic [3:0] sel);
    logic [31:0] r;
    logic [7:0]  t;
    for (int k = 0; k < 4; k++) begin
      t = sel[k] ? SboxB[b[8*k +: 8]] : SboxA[b[8*k +: 8]];
      r[8*k +: 8] = a[8*k +: 8] ^ t;
    end
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sbx_front.sv
// Front end: accepts items, tracks the byte position within the keystream word
// and tags each item for the back end. Depends on sbx_pkg.
`default_nettype none
module sbx_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_data_byte,
  input  wire sbx_pkg::sbx_qstat_t q_stat,
  output logic                   push,
  output sbx_pkg::sbx_op_t       push_op
);

  logic [1:0] pos_r, pos_nxt;

  // Stall while the queue is full
  assign in_stall = q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  // Tag the item
  always_comb begin
    push_op.is_start = ~in_mode;
    push_op.pos      = pos_r;
    push_op.data     = in_data_byte;
  end

  // Advance position on data, clear on start
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_mode ? pos_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sbx_queue.sv
// Short item queue between front and back end.
// Depends on sbx_pkg.
`default_nettype none
module sbx_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sbx_pkg::sbx_op_t    push_op,
  input  wire logic                pop,
  output sbx_pkg::sbx_op_t         pop_op,
  output sbx_pkg::sbx_qstat_t      q_stat
);

  sbx_pkg::sbx_op_t                 mem_r [sbx_pkg::QDepth];
  logic [sbx_pkg::QPtrW-1:0]        wptr_r, rptr_r;
  logic [sbx_pkg::QCntW-1:0]        cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == sbx_pkg::QCntW'(sbx_pkg::QDepth));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_op       = mem_r[rptr_r];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sbx_pkg::QCntW'(sbx_pkg::QDepth))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sbx_back.sv
// Back end: mixing state, three-phase update engine with one keystream word of
// lookahead, and the output register. Depends on sbx_pkg.
`default_nettype none
module sbx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbx_pkg::sbx_cfg_t cfg,
  input  wire sbx_pkg::sbx_qstat_t q_stat,
  input  wire sbx_pkg::sbx_op_t  q_op,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_crypt_byte
);

  logic [31:0]         z_r [sbx_pkg::NumWords];
  logic [31:0]         z_nxt [sbx_pkg::NumWords];
  logic [31:0]         cur_word_r;
  logic [31:0]         nxt_word_r;
  logic                nxt_valid_r, nxt_valid_nxt;
  logic [1:0]          warm_r, warm_nxt;
  sbx_pkg::sbx_phase_t phase_r, phase_nxt;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_free, take_start, take_data, take0;
  logic [31:0]         word_sel;
  logic [7:0]          ks_byte;
  logic [31:0]         post_word;

  assign out_valid      = out_valid_r;
  assign out_crypt_byte = out_byte_r;
  assign out_free       = ~out_valid_r | ~out_stall;

  // Pop a start at once; pop data when the output is free and its keystream is ready
  always_comb begin
    take_start = ~q_stat.empty & q_op.is_start;
    take_data  = ~q_stat.empty & ~q_op.is_start & out_free &
                 ((q_op.pos != 2'd0) | nxt_valid_r);
    take0      = take_data & (q_op.pos == 2'd0);
    pop        = take_start | take_data;
  end

  // Pick keystream byte, most significant first
  always_comb begin
    word_sel = take0 ? nxt_word_r : cur_word_r;
    case (q_op.pos)
      2'd0:    ks_byte = word_sel[31:24];
      2'd1:    ks_byte = word_sel[23:16];
      2'd2:    ks_byte = word_sel[15:8];
      default: ks_byte = word_sel[7:0];
    endcase
  end

  // Next phase of the update engine
  always_comb begin
    phase_nxt = phase_r;
    if (take_start) begin
      phase_nxt = sbx_pkg::PH_IDLE;
    end else begin
      case (phase_r)
        sbx_pkg::PH_IDLE: begin
          if (!nxt_valid_r || take0) phase_nxt = sbx_pkg::PH_PRE;
        end
        sbx_pkg::PH_PRE:  phase_nxt = sbx_pkg::PH_SUB;
        sbx_pkg::PH_SUB:  phase_nxt = sbx_pkg::PH_POST;
        sbx_pkg::PH_POST: begin
          phase_nxt = (warm_r != 2'd0) ? sbx_pkg::PH_PRE : sbx_pkg::PH_IDLE;
        end
        default:          phase_nxt = sbx_pkg::PH_IDLE;
      endcase
    end
  end

  // State datapath per phase
  always_comb begin
    for (int i = 0; i < sbx_pkg::NumWords; i++) begin
      z_nxt[i] = z_r[i];
    end
    post_word = '0;
    if (take_start) begin
      z_nxt[0]  = cfg.key_a[63:32];
      z_nxt[1]  = cfg.key_a[31:0];
      z_nxt[2]  = cfg.key_b[63:32];
      z_nxt[3]  = cfg.key_b[31:0];
      z_nxt[4]  = cfg.key_c[63:32];
      z_nxt[5]  = cfg.key_c[31:0];
      z_nxt[6]  = cfg.key_d[63:32];
      z_nxt[7]  = cfg.key_d[31:0];
      z_nxt[8]  = sbx_pkg::InitW8  ^ cfg.nonce_a[63:32];
      z_nxt[9]  = sbx_pkg::InitW9  ^ cfg.nonce_a[31:0];
      z_nxt[10] = sbx_pkg::InitW10 ^ cfg.nonce_b[63:32];
      z_nxt[11] = sbx_pkg::InitW11 ^ cfg.nonce_b[31:0];
    end else begin
      case (phase_r)
        sbx_pkg::PH_PRE: begin
          // Rotate/add/XOR pre-mixing, two rounds
          z_nxt[11] = sbx_pkg::rotl(z_r[11], 5'd16) ^ z_r[2];
          z_nxt[9]  = sbx_pkg::rotl(z_r[9], 5'd12) + z_r[0];
          z_nxt[5]  = z_r[5] + z_r[8];
          z_nxt[7]  = z_r[7] ^ z_r[10];
          z_nxt[1]  = z_r[1] + z_r[6];
          z_nxt[3]  = z_r[3] ^ z_r[4];
          z_nxt[10] = sbx_pkg::rotl(z_r[10], 5'd6) ^ z_nxt[11];
          z_nxt[8]  = sbx_pkg::rotl(z_r[8], 5'd31) + z_nxt[7];
          z_nxt[4]  = z_r[4] + z_nxt[5];
          z_nxt[6]  = z_r[6] ^ z_nxt[8];
          z_nxt[2]  = z_r[2] + z_nxt[1];
          z_nxt[0]  = z_r[0] ^ z_nxt[3];
        end
        sbx_pkg::PH_SUB: begin
          // Two layers of byte substitution
          z_nxt[3] = sbx_pkg::subst(z_r[3], z_r[0], 4'h1);
          z_nxt[5] = sbx_pkg::subst(z_r[5], z_r[2], 4'h2);
          z_nxt[7] = sbx_pkg::subst(z_r[7], z_r[4], 4'h4);
          z_nxt[1] = sbx_pkg::subst(z_r[1], z_r[6], 4'h8);
          z_nxt[2] = sbx_pkg::subst(z_r[2], z_nxt[1], 4'hE);
          z_nxt[4] = sbx_pkg::subst(z_r[4], z_nxt[3], 4'hD);
          z_nxt[0] = sbx_pkg::subst(z_r[0], z_nxt[5], 4'hB);
          z_nxt[6] = sbx_pkg::subst(z_r[6], z_nxt[7], 4'h7);
        end
        sbx_pkg::PH_POST: begin
          // Add/XOR post-mixing, then fold words 0 to 7
          z_nxt[3]  = z_r[3] + z_r[0];
          z_nxt[1]  = z_r[1] ^ z_r[2];
          z_nxt[7]  = z_r[7] + z_r[6];
          z_nxt[5]  = z_r[5] ^ z_r[4];
          z_nxt[0]  = z_r[0] + z_nxt[7];
          z_nxt[2]  = z_r[2] ^ z_nxt[5];
          z_nxt[4]  = z_r[4] + z_nxt[1];
          z_nxt[6]  = z_r[6] ^ z_nxt[3];
          z_nxt[8]  = z_r[8] + z_r[11];
          z_nxt[10] = z_r[10] ^ z_r[9];
          z_nxt[11] = z_r[11] + z_nxt[10];
          z_nxt[9]  = z_r[9] ^ z_nxt[8];
          post_word = z_nxt[0] ^ z_nxt[1] ^ z_nxt[2] ^ z_nxt[3] ^
                      z_nxt[4] ^ z_nxt[5] ^ z_nxt[6] ^ z_nxt[7];
        end
        default: ;
      endcase
    end
  end

  // Lookahead word and warm-up bookkeeping
  always_comb begin
    nxt_valid_nxt = nxt_valid_r;
    warm_nxt      = warm_r;
    if (take_start) begin
      nxt_valid_nxt = 1'b0;
      warm_nxt      = sbx_pkg::WarmUpdates;
    end else if (take0) begin
      nxt_valid_nxt = 1'b0;
    end else if (phase_r == sbx_pkg::PH_POST) begin
      if (warm_r != 2'd0) begin
        warm_nxt = warm_r - 2'd1;
      end else begin
        nxt_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbx_pkg::NumWords; i++) begin
        z_r[i] <= '0;
      end
      cur_word_r  <= '0;
      nxt_valid_r <= 1'b0;
      warm_r      <= 2'd0;
      phase_r     <= sbx_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < sbx_pkg::NumWords; i++) begin
        z_r[i] <= z_nxt[i];
      end
      nxt_valid_r <= nxt_valid_nxt;
      warm_r      <= warm_nxt;
      phase_r     <= phase_nxt;
      if (take0) begin
        cur_word_r <= nxt_word_r;
      end
      if (take_data) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!take_start && phase_r == sbx_pkg::PH_POST && warm_r == 2'd0) begin
      nxt_word_r <= post_word;
    end
    if (take_data) begin
      out_byte_r <= q_op.data ^ ks_byte;
    end
  end

`ifndef ASSERT_OFF
  a_engine_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != sbx_pkg::PH_IDLE) |-> !nxt_valid_r)
    else $error("update engine running while lookahead word is held");
  a_word_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    take0 |-> nxt_valid_r)
    else $error("first byte of word taken without fresh keystream");
  a_warm_range: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r <= sbx_pkg::WarmUpdates)
    else $error("warm-up count out of range");
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take_start |=> (phase_r == sbx_pkg::PH_IDLE) && !nxt_valid_r
                   && (warm_r == sbx_pkg::WarmUpdates))
    else $error("start did not restart the engine");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sbox_arx_stream_cipher_unit.sv
// A data item shows at out_valid after the queue and the output register; one byte a
// cycle sustained while out_stall stays low, since the update engine runs one word ahead.
// A start item yields nothing; the first byte after it waits while the engine leaves
// idle, runs two warm-up updates and then one lookahead update.
// Reset (rst_n low, synchronous) clears the registers, state, position and queue.
// Top level: configuration registers, front end, queue, back end.
`default_nettype none
module sbox_arx_stream_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_crypt_byte,
  input  wire logic        cfg_we,
  input  wire logic [sbx_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [63:0] cfg_wdata
);

  sbx_pkg::sbx_cfg_t   cfg_r;
  sbx_pkg::sbx_qstat_t q_stat;
  sbx_pkg::sbx_op_t    push_op, pop_op;
  logic                push, pop;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sbx_pkg::REG_KEY_A:   cfg_r.key_a   <= cfg_wdata;
        sbx_pkg::REG_KEY_B:   cfg_r.key_b   <= cfg_wdata;
        sbx_pkg::REG_KEY_C:   cfg_r.key_c   <= cfg_wdata;
        sbx_pkg::REG_KEY_D:   cfg_r.key_d   <= cfg_wdata;
        sbx_pkg::REG_NONCE_A: cfg_r.nonce_a <= cfg_wdata;
        sbx_pkg::REG_NONCE_B: cfg_r.nonce_b <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sbx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_op      (push_op)
  );

  sbx_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  sbx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_stat         (q_stat),
    .q_op           (pop_op),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_crypt_byte (out_crypt_byte)
  );

endmodule
`default_nettype wire
